>>> src/bidr_pkg.sv
// Shared types, codes and the CRC-8 step for the breaker ID registration frame receiver.
package bidr_pkg;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEAD     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_REPORT_COMMAND = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACK_COMMAND    = 2'd2;

	localparam logic [7:0] FRAME_HEAD_RESET = 8'h5A;

	// CRC-8, polynomial 0x01, MSB first.
	localparam logic [7:0] CRC_POLY = 8'h01;

	// Status codes of the status transaction.
	localparam logic [2:0] STAT_NEW     = 3'd0;
	localparam logic [2:0] STAT_KNOWN   = 3'd1;
	localparam logic [2:0] STAT_BAD_HDR = 3'd2;
	localparam logic [2:0] STAT_BAD_CMD = 3'd3;
	localparam logic [2:0] STAT_CRC_ERR = 3'd4;
	localparam logic [2:0] STAT_FULL    = 3'd5;

	localparam int unsigned OUT_DATA_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RD,
		ST_CMP,
		ST_COMMIT,
		ST_STATUS,
		ST_ACK
	} bidr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_byte;
		logic check;
		logic cmp;
		logic commit;
		logic emit_status;
		logic emit_ack;
	} bidr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_done;
		logic pre_fail;
		logic hit;
		logic scan_end;
		logic ack_needed;
		logic out_free;
		logic ack_end;
	} bidr_stat_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> src/breaker_id_registration_frame.sv
// Top level of the breaker ID registration frame receiver.
// A byte that is not the last of its frame is taken whenever it is valid and the receiver is idle.
// After the last byte, a bad frame goes from the check straight to the status transaction;
// otherwise the slot scan (one memory read and one compare per slot) runs first, up to a hit;
// the acknowledge bytes then follow one a cycle while the sink is ready.
// Reset clears the counters, CRC, slot valid bits and output valid flag at once.
module breaker_id_registration_frame #(
	parameter int unsigned SLOTS       = 8,
	parameter int unsigned FRAME_BYTES = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // rx_byte
	input  logic                                 s_tuser,   // frame_start
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bidr_pkg::OUT_DATA_W-1:0]      m_tdata,   // status, slot_number, tx_byte, pad
	output logic                                 m_tuser,   // is_status
	output logic                                 m_tlast,   // last
	input  logic                                 cfg_we,
	input  logic [bidr_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [7:0]                           cfg_data
);

	// The controller sequences a frame through check, slot scan, commit and emission (a bad frame
	// skips scan and commit, a known ID skips commit); the datapath holds the other registers and the slot table.
	bidr_pkg::bidr_cmd_t  cmd;
	bidr_pkg::bidr_stat_t stat;

	logic       out_is_status, out_last;
	logic [2:0] out_status;
	logic [3:0] out_slot;
	logic [7:0] out_tx;

	bidr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bidr_dp #(
		.SLOTS       (SLOTS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (s_tdata),
		.frame_start   (s_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_is_status (out_is_status),
		.out_status    (out_status),
		.out_slot      (out_slot),
		.out_tx        (out_tx),
		.out_last      (out_last)
	);

	// The result transaction is packed with the status code in the lowest bits, then the
	// channel number, then the acknowledge byte, and a zero bit to fill the word.
	assign m_tdata = {1'b0, out_tx, out_slot, out_status};
	assign m_tuser = out_is_status;
	assign m_tlast = out_last;

endmodule

>>> src/bidr_ctrl.sv
// Controller state machine of the breaker ID registration frame receiver.
module bidr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bidr_pkg::bidr_stat_t stat,
	output bidr_pkg::bidr_cmd_t  cmd
);

	bidr_pkg::bidr_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bidr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bidr_pkg::ST_IDLE: begin
				if (in_valid && stat.frame_done) begin
					state_next = bidr_pkg::ST_CHECK;
				end
			end
			bidr_pkg::ST_CHECK: begin
				state_next = stat.pre_fail ? bidr_pkg::ST_STATUS : bidr_pkg::ST_RD;
			end
			bidr_pkg::ST_RD: begin
				state_next = bidr_pkg::ST_CMP;
			end
			bidr_pkg::ST_CMP: begin
				if (stat.hit) begin
					state_next = bidr_pkg::ST_STATUS;
				end else if (stat.scan_end) begin
					state_next = bidr_pkg::ST_COMMIT;
				end else begin
					state_next = bidr_pkg::ST_RD;
				end
			end
			bidr_pkg::ST_COMMIT: begin
				state_next = bidr_pkg::ST_STATUS;
			end
			bidr_pkg::ST_STATUS: begin
				if (stat.out_free) begin
					state_next = stat.ack_needed ? bidr_pkg::ST_ACK : bidr_pkg::ST_IDLE;
				end
			end
			bidr_pkg::ST_ACK: begin
				if (stat.out_free && stat.ack_end) begin
					state_next = bidr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bidr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			bidr_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_byte = in_valid;
			end
			bidr_pkg::ST_CHECK:  cmd.check = 1'b1;
			bidr_pkg::ST_RD:     ;
			bidr_pkg::ST_CMP:    cmd.cmp = 1'b1;
			bidr_pkg::ST_COMMIT: cmd.commit = 1'b1;
			bidr_pkg::ST_STATUS: cmd.emit_status = stat.out_free;
			bidr_pkg::ST_ACK:    cmd.emit_ack = stat.out_free;
			default: ;
		endcase
	end

endmodule

>>> src/bidr_dp.sv
// Datapath: frame capture, CRC, slot table, acknowledge builder and output register.
module bidr_dp #(
	parameter int unsigned SLOTS       = 8,
	parameter int unsigned FRAME_BYTES = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        rx_byte,
	input  logic                              frame_start,
	input  logic                              cfg_we,
	input  logic [bidr_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data,
	input  bidr_pkg::bidr_cmd_t               cmd,
	output bidr_pkg::bidr_stat_t              stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_is_status,
	output logic [2:0]                        out_status,
	output logic [3:0]                        out_slot,
	output logic [7:0]                        out_tx,
	output logic                              out_last
);

	localparam int unsigned CW = $clog2(FRAME_BYTES);
	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
	localparam logic [7:0] LEN_BYTE = 8'(FRAME_BYTES);

	// Configuration registers.
	logic [7:0] frame_head_q, report_command_q, ack_command_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_head_q     <= bidr_pkg::FRAME_HEAD_RESET;
			report_command_q <= '0;
			ack_command_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bidr_pkg::REG_FRAME_HEAD:     frame_head_q     <= cfg_data;
				bidr_pkg::REG_REPORT_COMMAND: report_command_q <= cfg_data;
				bidr_pkg::REG_ACK_COMMAND:    ack_command_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame capture. Only the bytes that are checked or echoed are kept.
	logic [CW-1:0] cnt_q, idx;
	logic [7:0]    crc_q;
	logic [7:0]    head_byte_q, len_byte_q, cmd_byte_q, crc_rx_q;
	logic [7:0]    id_byte_q [4];
	logic [31:0]   id;

	assign idx = frame_start ? '0 : cnt_q;
	assign id  = {id_byte_q[0], id_byte_q[1], id_byte_q[2], id_byte_q[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= '0;
		end else if (cmd.take_byte) begin
			cnt_q <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
			if (idx == '0) begin
				crc_q <= bidr_pkg::crc8_byte(8'h00, rx_byte);
			end else if (idx != LAST_IDX) begin
				crc_q <= bidr_pkg::crc8_byte(crc_q, rx_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			if (idx == CW'(0)) head_byte_q <= rx_byte;
			if (idx == CW'(1)) len_byte_q <= rx_byte;
			if (idx == CW'(2)) cmd_byte_q <= rx_byte;
			if (idx >= CW'(3) && idx <= CW'(6)) id_byte_q[idx[1:0] + 2'd1] <= rx_byte;
			if (idx == LAST_IDX) crc_rx_q <= rx_byte;
		end
	end

	// Frame checks in priority order.
	logic [2:0] pre_code;
	always_comb begin
		if (head_byte_q != frame_head_q || len_byte_q != LEN_BYTE) begin
			pre_code = bidr_pkg::STAT_BAD_HDR;
		end else if (cmd_byte_q != report_command_q) begin
			pre_code = bidr_pkg::STAT_BAD_CMD;
		end else if (crc_rx_q != crc_q) begin
			pre_code = bidr_pkg::STAT_CRC_ERR;
		end else begin
			pre_code = bidr_pkg::STAT_FULL;
		end
	end

	// Slot table: IDs in a memory, valid bits in flip-flops.
	logic [31:0]      slot_mem [SLOTS];
	logic [31:0]      rd_id_q;
	logic [SLOTS-1:0] slot_used_q;
	logic [SW-1:0]    scan_idx_q, free_idx_q;
	logic             free_found_q;
	logic [2:0]       status_q;
	logic [3:0]       slot_q;
	logic             hit;

	assign hit = slot_used_q[scan_idx_q] && (rd_id_q == id);

	always_ff @(posedge clk) begin
		if (cmd.commit && free_found_q) begin
			slot_mem[free_idx_q] <= id;
		end
		rd_id_q <= slot_mem[scan_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q  <= '0;
			scan_idx_q   <= '0;
			free_idx_q   <= '0;
			free_found_q <= 1'b0;
			status_q     <= bidr_pkg::STAT_NEW;
			slot_q       <= '0;
		end else if (cmd.check) begin
			status_q     <= pre_code;
			slot_q       <= '0;
			scan_idx_q   <= '0;
			free_found_q <= 1'b0;
		end else if (cmd.cmp) begin
			if (hit) begin
				status_q <= bidr_pkg::STAT_KNOWN;
				slot_q   <= 4'({1'b0, scan_idx_q} + 1'b1);
			end else if (!slot_used_q[scan_idx_q] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= scan_idx_q;
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end else if (cmd.commit && free_found_q) begin
			slot_used_q[free_idx_q] <= 1'b1;
			status_q                <= bidr_pkg::STAT_NEW;
			slot_q                  <= 4'({1'b0, free_idx_q} + 1'b1);
		end
	end

	// Acknowledge frame builder.
	logic [CW-1:0] tx_idx_q;
	logic [7:0]    tx_crc_q, ack_byte;

	always_comb begin
		if (tx_idx_q == CW'(0)) begin
			ack_byte = frame_head_q;
		end else if (tx_idx_q == CW'(1)) begin
			ack_byte = LEN_BYTE;
		end else if (tx_idx_q == CW'(2)) begin
			ack_byte = ack_command_q;
		end else if (tx_idx_q >= CW'(3) && tx_idx_q <= CW'(6)) begin
			ack_byte = id_byte_q[tx_idx_q[1:0] + 2'd1];
		end else if (tx_idx_q == LAST_IDX) begin
			ack_byte = tx_crc_q;
		end else begin
			ack_byte = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_idx_q <= '0;
			tx_crc_q <= '0;
		end else if (cmd.emit_status) begin
			tx_idx_q <= '0;
			tx_crc_q <= '0;
		end else if (cmd.emit_ack) begin
			tx_idx_q <= tx_idx_q + 1'b1;
			tx_crc_q <= bidr_pkg::crc8_byte(tx_crc_q, ack_byte);
		end
	end

	// Output register.
	logic       out_valid_q, out_is_status_q, out_last_q;
	logic [2:0] out_status_q;
	logic [3:0] out_slot_q;
	logic [7:0] out_tx_q;
	logic       ack_needed;

	assign ack_needed = (status_q == bidr_pkg::STAT_NEW) || (status_q == bidr_pkg::STAT_KNOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_status || cmd.emit_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_status) begin
			out_is_status_q <= 1'b1;
			out_status_q    <= status_q;
			out_slot_q      <= ack_needed ? slot_q : 4'd0;
			out_tx_q        <= 8'h00;
			out_last_q      <= !ack_needed;
		end else if (cmd.emit_ack) begin
			out_is_status_q <= 1'b0;
			out_status_q    <= 3'd0;
			out_slot_q      <= 4'd0;
			out_tx_q        <= ack_byte;
			out_last_q      <= (tx_idx_q == LAST_IDX);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_is_status = out_is_status_q;
	assign out_status    = out_status_q;
	assign out_slot      = out_slot_q;
	assign out_tx        = out_tx_q;
	assign out_last      = out_last_q;

	assign stat.frame_done = (idx == LAST_IDX);
	assign stat.pre_fail   = (pre_code != bidr_pkg::STAT_FULL);
	assign stat.hit        = hit;
	assign stat.scan_end   = (scan_idx_q == LAST_SLOT);
	assign stat.ack_needed = ack_needed;
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.ack_end    = (tx_idx_q == LAST_IDX);

endmodule

>>> src/bidr_chk.sv
// Port checker for the breaker ID registration frame receiver, bound to the top level.
module bidr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled result transaction holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result transaction changed while stalled");

	// Acknowledge bytes carry no status or channel; status transactions carry no byte.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser ? (m_tdata[14:7] == 8'h00) : (m_tdata[6:0] == 7'h00)))
		else $error("result fields mixed between kinds");

	// A failed frame ends at its status with no channel number.
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[2:0] != bidr_pkg::STAT_NEW
		&& m_tdata[2:0] != bidr_pkg::STAT_KNOWN
		|-> m_tlast && m_tdata[6:3] == 4'd0)
		else $error("failed status not final");

	// A successful status, once taken, is not directly followed by another status.
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> !(m_tvalid && m_tuser))
		else $error("acknowledge frame missing after status");

endmodule

bind breaker_id_registration_frame bidr_chk u_bidr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
